>>> src/ktas_pkg.sv
// shared types and constants for the keyed table with append store
`default_nettype none

package ktas_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam int KEY_W    = 32;
    localparam int OFF_W    = 32;
    localparam int LEN_W    = 16;
    localparam int CAP_W    = 7;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int USED_W   = 33;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE     = 1'b1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_NOSPACE  = 3'd4
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] length;
    } t_entry;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

>>> src/keyed_table_with_append_store_core.sv
// top level of the keyed table with append store: search sequencer and result register
//
// channel   dir  signals                    contents (lowest bit up)
// s_axis    in   tvalid tready tdata tuser  tdata: key[31:0] record_length[47:32]; tuser: operation
// m_axis    out  tvalid tready tdata tuser  tdata: entry_index[5:0] record_offset[37:6]
//                                                  entry_length[53:38]; tuser: status
// cfg       in   we addr wdata              addr 0 table_capacity, addr 1 store_base
//
// an item runs through these steps in order: accept, one key read per filled slot through
// the single read port of the entry store, a compare of the last key, a step to see the
// scan is done, and a step to resolve and load the result register; a key hit stops the
// scan early
// the resolve step waits while the result register holds a beat not yet taken
// reset clears the fill count, bytes used, store_base and the result valid flag, and sets table_capacity to 64
`default_nettype none

module keyed_table_with_append_store_core #(
    parameter int TABLE_DEPTH = ktas_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config write port
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_addr,
    input  wire  [31:0] i_cfg_wdata,
    // input beats
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [47:0] i_s_axis_tdata,   // key[31:0], record_length[47:32]
    input  wire  [0:0]  i_s_axis_tuser,   // operation
    // result beats
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // entry_index[5:0], record_offset[37:6],
                                          // entry_length[53:38], zero fill
    output logic [2:0]  o_m_axis_tuser    // status
);

    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = ((CW > ktas_pkg::CAP_W) ? CW : ktas_pkg::CAP_W) + 1;
    localparam int ENDW = ktas_pkg::USED_W + 1;
    localparam int SUMW = ENDW + 1;

    localparam logic [CW-1:0]   DEPTH_CNT = CW'(TABLE_DEPTH);
    localparam logic [SUMW-1:0] STORE_TOP = SUMW'(64'h1_0000_0000);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_RESULT = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic                           r_op;
    logic [ktas_pkg::KEY_W-1:0]     r_key;
    logic [ktas_pkg::LEN_W-1:0]     r_len;
    logic [ENDW-1:0]                r_end;

    logic [CW-1:0]                  r_slot, n_slot;
    logic                           r_pend, n_pend;
    logic [IW-1:0]                  r_pend_slot, n_pend_slot;
    logic                           r_found, n_found;
    logic [IW-1:0]                  r_found_slot, n_found_slot;

    logic [CW-1:0]                  r_filled, n_filled;
    logic [ktas_pkg::USED_W-1:0]    r_used, n_used;
    logic [ktas_pkg::CAP_W-1:0]     r_cap;
    logic [ktas_pkg::OFF_W-1:0]     r_base;

    logic                           r_out_vld, n_out_vld;
    ktas_pkg::t_status              r_out_status, n_out_status;
    logic [ktas_pkg::INDEX_W-1:0]   r_out_idx, n_out_idx;
    logic [ktas_pkg::OFF_W-1:0]     r_out_off, n_out_off;
    logic [ktas_pkg::LEN_W-1:0]     r_out_len, n_out_len;

    ktas_pkg::t_mem_ctl             w_mem_ctl;
    ktas_pkg::t_entry               w_wr_entry;
    ktas_pkg::t_entry               w_rd_entry;

    logic                           w_in_acc;
    logic                           w_out_free;
    logic                           w_hit;
    logic                           w_more;
    logic                           w_issue;
    logic                           w_full;
    logic                           w_nospace;
    logic [SUMW-1:0]                w_sum;
    logic [IW+ktas_pkg::INDEX_W-1:0] w_found_idx;
    logic [IW+ktas_pkg::INDEX_W-1:0] w_new_idx;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_vld || i_m_axis_tready;

    assign w_hit   = r_pend && (w_rd_entry.key == r_key);
    assign w_more  = (r_slot < r_filled);
    assign w_issue = w_more && !w_hit;

    assign w_full = (CMPW'(r_filled) >= CMPW'(r_cap)) || (r_filled == DEPTH_CNT);
    assign w_sum  = SUMW'(r_end) + SUMW'(r_len);
    assign w_nospace = (w_sum > STORE_TOP);

    assign w_found_idx = {{ktas_pkg::INDEX_W{1'b0}}, r_found_slot};
    assign w_new_idx   = {{ktas_pkg::INDEX_W{1'b0}}, r_filled[IW-1:0]};

    assign w_wr_entry = '{key: r_key, offset: r_end[ktas_pkg::OFF_W-1:0], length: r_len};

    always_comb begin
        n_state      = r_state;
        n_slot       = r_slot;
        n_pend       = r_pend;
        n_pend_slot  = r_pend_slot;
        n_found      = r_found;
        n_found_slot = r_found_slot;
        n_filled     = r_filled;
        n_used       = r_used;
        n_out_vld    = r_out_vld && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_off    = r_out_off;
        n_out_len    = r_out_len;
        w_mem_ctl    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_SEARCH;
                    n_slot  = '0;
                    n_pend  = 1'b0;
                end
            end
            S_SEARCH: begin
                n_pend = w_issue;
                if (w_issue) begin
                    w_mem_ctl.rd_en = 1'b1;
                    n_slot          = r_slot + CW'(1);
                    n_pend_slot     = r_slot[IW-1:0];
                end
                if (w_hit) begin
                    n_found      = 1'b1;
                    n_found_slot = r_pend_slot;
                    n_state      = S_RESULT;
                end else if (!w_more && !r_pend) begin
                    n_found = 1'b0;
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_out_vld    = 1'b1;
                    n_state      = S_IDLE;
                    n_out_status = ktas_pkg::ST_OK;
                    n_out_idx    = '0;
                    n_out_off    = '0;
                    n_out_len    = '0;
                    if (r_op) begin
                        if (r_found) begin
                            n_out_idx = w_found_idx[ktas_pkg::INDEX_W-1:0];
                            n_out_off = w_rd_entry.offset;
                            n_out_len = w_rd_entry.length;
                        end else begin
                            n_out_status = ktas_pkg::ST_NOTFOUND;
                        end
                    end else begin
                        priority if (r_found) begin
                            n_out_status = ktas_pkg::ST_DUP;
                        end else if (w_full) begin
                            n_out_status = ktas_pkg::ST_FULL;
                        end else if (w_nospace) begin
                            n_out_status = ktas_pkg::ST_NOSPACE;
                        end else begin
                            w_mem_ctl.wr_en = 1'b1;
                            n_filled  = r_filled + CW'(1);
                            n_used    = r_used + ktas_pkg::USED_W'(r_len);
                            n_out_idx = w_new_idx[ktas_pkg::INDEX_W-1:0];
                            n_out_off = r_end[ktas_pkg::OFF_W-1:0];
                            n_out_len = r_len;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_filled  <= '0;
            r_used    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_found   <= n_found;
            r_filled  <= n_filled;
            r_used    <= n_used;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= ktas_pkg::CAPACITY_RESET;
            r_base <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ktas_pkg::CFG_IDX_CAPACITY: r_cap  <= i_cfg_wdata[ktas_pkg::CAP_W-1:0];
                ktas_pkg::CFG_IDX_BASE:     r_base <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op  <= i_s_axis_tuser[0];
            r_key <= i_s_axis_tdata[ktas_pkg::KEY_W-1:0];
            r_len <= i_s_axis_tdata[ktas_pkg::KEY_W +: ktas_pkg::LEN_W];
            r_end <= ENDW'(r_base) + ENDW'(r_used);
        end
        r_slot       <= n_slot;
        r_pend_slot  <= n_pend_slot;
        r_found_slot <= n_found_slot;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_off    <= n_out_off;
        r_out_len    <= n_out_len;
    end

    ktas_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (IW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_ctl      (w_mem_ctl),
        .i_wr_addr  (r_filled[IW-1:0]),
        .i_wr_entry (w_wr_entry),
        .i_rd_addr  (r_slot[IW-1:0]),
        .o_rd_entry (w_rd_entry)
    );

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {2'b00, r_out_len, r_out_off, r_out_idx};

endmodule

`default_nettype wire

>>> src/ktas_mem.sv
// entry store: one write port, one registered read port
`default_nettype none

module ktas_mem #(
    parameter int TABLE_DEPTH = ktas_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire                   i_clk,
    input  ktas_pkg::t_mem_ctl    i_ctl,
    input  wire  [AW-1:0]         i_wr_addr,
    input  ktas_pkg::t_entry      i_wr_entry,
    input  wire  [AW-1:0]         i_rd_addr,
    output ktas_pkg::t_entry      o_rd_entry
);

    ktas_pkg::t_entry r_mem [TABLE_DEPTH];
    ktas_pkg::t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

`default_nettype wire
